// ===== hw/rtl/rcpwd_pkg.sv =====
// ----------------------------------------------------------------------------
// rcpwd_pkg
// Shared types and constants for the RC pulse-width decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package rcpwd_pkg;

    // Number of tracked receiver lines and reported channels.
    localparam int CHANNELS   = 4;
    localparam int OUT_CH     = 4;
    localparam int COUNT_BITS = 16;

    // Field widths.
    localparam int LEVEL_W   = 4;
    localparam int PULSE_W   = 12;
    localparam int TIMEOUT_W = 16;
    localparam int CMP_W     = (COUNT_BITS > TIMEOUT_W) ? COUNT_BITS : TIMEOUT_W;

    // Stream widths, padded to whole bytes.
    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 56;

    // Configuration port.
    localparam int ADDR_W = 5;
    localparam int APB_W  = 32;
    localparam int IDX_W  = 3;

    typedef enum logic [IDX_W-1:0] {
        REG_PULSE_MIN      = 3'd0,
        REG_PULSE_MAX      = 3'd1,
        REG_FALLBACK_PULSE = 3'd2,
        REG_LOSS_TIMEOUT   = 3'd3,
        REG_MODE_THRESHOLD = 3'd4
    } reg_idx_t;

    localparam logic [PULSE_W-1:0]   PULSE_MIN_RST      = 12'd1000;
    localparam logic [PULSE_W-1:0]   PULSE_MAX_RST      = 12'd2000;
    localparam logic [PULSE_W-1:0]   FALLBACK_PULSE_RST = 12'd1500;
    localparam logic [TIMEOUT_W-1:0] LOSS_TIMEOUT_RST   = 16'd50000;
    localparam logic [PULSE_W-1:0]   MODE_THRESHOLD_RST = 12'd1500;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef struct packed {
        logic [PULSE_W-1:0]   pulse_min;
        logic [PULSE_W-1:0]   pulse_max;
        logic [PULSE_W-1:0]   fallback_pulse;
        logic [TIMEOUT_W-1:0] loss_timeout;
        logic [PULSE_W-1:0]   mode_threshold;
    } cfg_t;

    typedef struct packed {
        logic [PULSE_W-1:0] value;
        logic               lost;
    } ch_result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rcpwd_regs.sv =====
// ----------------------------------------------------------------------------
// rcpwd_regs
// APB register file holding the decoder configuration.
// ----------------------------------------------------------------------------
`default_nettype none

module rcpwd_regs (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [rcpwd_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [rcpwd_pkg::APB_W-1:0]   pwdata,
    output logic      [rcpwd_pkg::APB_W-1:0]   prdata,
    output logic                               pready,
    output rcpwd_pkg::cfg_t                    cfg
);

    rcpwd_pkg::cfg_t cfg_reg;
    rcpwd_pkg::cfg_t cfg_next;
    logic [rcpwd_pkg::IDX_W-1:0] idx;
    logic wr_en;

    assign pready = 1'b1;
    assign idx    = paddr[rcpwd_pkg::ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (idx)
                rcpwd_pkg::REG_PULSE_MIN:
                    cfg_next.pulse_min = pwdata[rcpwd_pkg::PULSE_W-1:0];
                rcpwd_pkg::REG_PULSE_MAX:
                    cfg_next.pulse_max = pwdata[rcpwd_pkg::PULSE_W-1:0];
                rcpwd_pkg::REG_FALLBACK_PULSE:
                    cfg_next.fallback_pulse = pwdata[rcpwd_pkg::PULSE_W-1:0];
                rcpwd_pkg::REG_LOSS_TIMEOUT:
                    cfg_next.loss_timeout = pwdata[rcpwd_pkg::TIMEOUT_W-1:0];
                rcpwd_pkg::REG_MODE_THRESHOLD:
                    cfg_next.mode_threshold = pwdata[rcpwd_pkg::PULSE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pulse_min      <= rcpwd_pkg::PULSE_MIN_RST;
            cfg_reg.pulse_max      <= rcpwd_pkg::PULSE_MAX_RST;
            cfg_reg.fallback_pulse <= rcpwd_pkg::FALLBACK_PULSE_RST;
            cfg_reg.loss_timeout   <= rcpwd_pkg::LOSS_TIMEOUT_RST;
            cfg_reg.mode_threshold <= rcpwd_pkg::MODE_THRESHOLD_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        prdata = '0;
        case (idx)
            rcpwd_pkg::REG_PULSE_MIN:
                prdata = rcpwd_pkg::APB_W'(cfg_reg.pulse_min);
            rcpwd_pkg::REG_PULSE_MAX:
                prdata = rcpwd_pkg::APB_W'(cfg_reg.pulse_max);
            rcpwd_pkg::REG_FALLBACK_PULSE:
                prdata = rcpwd_pkg::APB_W'(cfg_reg.fallback_pulse);
            rcpwd_pkg::REG_LOSS_TIMEOUT:
                prdata = rcpwd_pkg::APB_W'(cfg_reg.loss_timeout);
            rcpwd_pkg::REG_MODE_THRESHOLD:
                prdata = rcpwd_pkg::APB_W'(cfg_reg.mode_threshold);
            default: prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/rcpwd_channel.sv =====
// ----------------------------------------------------------------------------
// rcpwd_channel
// Per-line pulse capture, age tracking and clamp/fallback selection.
// ----------------------------------------------------------------------------
`default_nettype none

module rcpwd_channel (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   step,
    input  wire logic                   level_now,
    input  wire logic                   level_before,
    input  rcpwd_pkg::cfg_t             cfg,
    output rcpwd_pkg::ch_result_t       result
);

    logic                             armed_reg, armed_next;
    logic                             capd_reg, capd_next;
    logic [rcpwd_pkg::COUNT_BITS-1:0] hcnt_reg, hcnt_next;
    logic [rcpwd_pkg::COUNT_BITS-1:0] width_reg, width_next;
    logic [rcpwd_pkg::COUNT_BITS-1:0] age_reg, age_next;
    logic                             captured;
    logic                             fallback;
    logic [rcpwd_pkg::COUNT_BITS-1:0] lo_ext, hi_ext;

    // Edge tracking and counter updates for one tick.
    always_comb begin
        armed_next = armed_reg;
        capd_next  = capd_reg;
        hcnt_next  = hcnt_reg;
        width_next = width_reg;
        captured   = 1'b0;
        if (level_now && !level_before) begin
            armed_next = 1'b1;
            hcnt_next  = '0;
        end else if (armed_reg) begin
            hcnt_next = (hcnt_reg == rcpwd_pkg::COUNT_MAX) ? hcnt_reg : hcnt_reg + 1'b1;
            if (!level_now && level_before) begin
                width_next = hcnt_next;
                capd_next  = 1'b1;
                armed_next = 1'b0;
                captured   = 1'b1;
            end
        end
        if (captured) begin
            age_next = '0;
        end else begin
            age_next = (age_reg == rcpwd_pkg::COUNT_MAX) ? age_reg : age_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            armed_reg <= 1'b0;
            capd_reg  <= 1'b0;
            hcnt_reg  <= '0;
            width_reg <= '0;
            age_reg   <= '0;
        end else if (step) begin
            armed_reg <= armed_next;
            capd_reg  <= capd_next;
            hcnt_reg  <= hcnt_next;
            width_reg <= width_next;
            age_reg   <= age_next;
        end
    end

    // The reported value reflects the state after this tick's update.
    assign lo_ext   = rcpwd_pkg::COUNT_BITS'(cfg.pulse_min);
    assign hi_ext   = rcpwd_pkg::COUNT_BITS'(cfg.pulse_max);
    assign fallback = !capd_next || (width_next == '0) ||
                      (rcpwd_pkg::CMP_W'(age_next) > rcpwd_pkg::CMP_W'(cfg.loss_timeout));

    always_comb begin
        result.lost = fallback;
        if (fallback) begin
            result.value = cfg.fallback_pulse;
        end else if (width_next < lo_ext) begin
            result.value = cfg.pulse_min;
        end else if (width_next > hi_ext) begin
            result.value = cfg.pulse_max;
        end else begin
            result.value = width_next[rcpwd_pkg::PULSE_W-1:0];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/rc_pulse_width_decoder_core.sv =====
// ----------------------------------------------------------------------------
// rc_pulse_width_decoder_core
// Four-channel RC receiver pulse-width decoder with loss detection.
// ----------------------------------------------------------------------------
// Usage: each transfer on the s_ channel is one timer tick carrying the
// sampled levels of the receiver lines in s_tdata[3:0]. Every accepted tick
// produces exactly one transfer on the m_ channel with the four channel
// widths (clamped to the configured window, or the fallback value when a
// channel has never captured, holds a zero width or has timed out), the
// lost mask and the stabilize flag.
// The result of a tick is presented on m_tvalid in the cycle after it is
// accepted. Throughput is one tick per cycle while m_tready is high; the
// limit is the single result register, which is reloaded in the same cycle
// that the downstream side takes its contents.
// When the receiver stalls, the result register holds its transfer and
// s_tready drops, so no tick is taken until the result is consumed.
// Reset (aresetn low, synchronous) clears all capture state, empties the
// result register and loads the configuration registers with their defaults.
// The user must write configuration through the APB port only while the stream is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module rc_pulse_width_decoder_core (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // s_tdata: [3:0] line_levels, [7:4] zero
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [rcpwd_pkg::S_DATA_W-1:0]  s_tdata,
    // m_tdata: [11:0] pulse_ch1, [23:12] pulse_ch2, [35:24] pulse_ch3,
    //          [47:36] pulse_ch4, [51:48] lost_mask, [52] stabilize, [55:53] zero
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic      [rcpwd_pkg::M_DATA_W-1:0]  m_tdata,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [rcpwd_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [rcpwd_pkg::APB_W-1:0]     pwdata,
    output logic      [rcpwd_pkg::APB_W-1:0]     prdata,
    output logic                                 pready
);

    rcpwd_pkg::cfg_t                cfg;
    rcpwd_pkg::ch_result_t          ch_res [rcpwd_pkg::OUT_CH];
    logic [rcpwd_pkg::LEVEL_W-1:0]  levels;
    logic [rcpwd_pkg::LEVEL_W-1:0]  prev_levels_reg;
    logic                           accept;
    logic                           m_tvalid_reg, m_tvalid_next;
    logic [rcpwd_pkg::M_DATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [rcpwd_pkg::OUT_CH-1:0]   lost_mask;
    logic                           stabilize;

    rcpwd_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // A new tick is taken whenever the result register is empty or is being
    // drained in this same cycle.
    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign levels   = s_tdata[rcpwd_pkg::LEVEL_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_levels_reg <= '0;
        end else if (accept) begin
            prev_levels_reg <= levels;
        end
    end

    // One capture unit per existing channel; absent channels always fall back.
    for (genvar i = 0; i < rcpwd_pkg::OUT_CH; i++) begin : g_ch
        if (i < rcpwd_pkg::CHANNELS) begin : g_live
            rcpwd_channel u_ch (
                .aclk         (aclk),
                .aresetn      (aresetn),
                .step         (accept),
                .level_now    (levels[i]),
                .level_before (prev_levels_reg[i]),
                .cfg          (cfg),
                .result       (ch_res[i])
            );
        end else begin : g_absent
            assign ch_res[i].value = cfg.fallback_pulse;
            assign ch_res[i].lost  = 1'b1;
        end
        assign lost_mask[i] = ch_res[i].lost;
    end

    // Stabilize follows the value actually reported on the fourth channel.
    assign stabilize = (ch_res[3].value >= cfg.mode_threshold);

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (accept) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {3'b000, stabilize, lost_mask,
                             ch_res[3].value, ch_res[2].value,
                             ch_res[1].value, ch_res[0].value};
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/rcpwd_checker.sv =====
// ----------------------------------------------------------------------------
// rcpwd_checker
// Port-level checks of the decoder stream handshake and result timing.
// ----------------------------------------------------------------------------
`default_nettype none

module rcpwd_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            s_tvalid,
    input wire logic                            s_tready,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [rcpwd_pkg::M_DATA_W-1:0]  m_tdata
);

    // A stalled result keeps its contents.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Every accepted tick shows a result in the following cycle.
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted tick produced no result");

    // A result never appears without a tick accepted the cycle before.
    a_no_invent: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready))
        else $error("result appeared without an accepted tick");

    // With the result register empty, the input side is always open.
    a_ready_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled while result register empty");

endmodule

bind rc_pulse_width_decoder_core rcpwd_checker u_rcpwd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// ===== test/rc_pulse_width_decoder_core_tb.sv =====
// ----------------------------------------------------------------------------
// rc_pulse_width_decoder_core_tb
// Self-checking testbench for the four-channel RC pulse-width decoder.
// Ticks of sampled line levels are streamed into the core while a local model
// of the capture logic predicts every result transfer; each result is compared
// field by field against the oldest prediction. Directed tests cover reset
// defaults, open and inverted clamp windows and zero and short
// timeouts; random phases then run pulse trains with noise under many
// register settings, with random stalls on both streams.
// ----------------------------------------------------------------------------
`default_nettype none

module rc_pulse_width_decoder_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 6;
    localparam int MAX_IDLE      = 12;
    localparam int SETTLE_CYCLES = 4;
    localparam int RANDOM_TICKS  = 1550;
    localparam int RANDOM_PHASES = 6;
    localparam int PAD_W         = rcpwd_pkg::M_DATA_W
                                   - rcpwd_pkg::OUT_CH * rcpwd_pkg::PULSE_W
                                   - rcpwd_pkg::OUT_CH - 1;

    // Layout of one result transfer; pulse[0] sits in the lowest bits.
    typedef struct packed {
        logic [PAD_W-1:0]                                       pad;
        logic                                                   stabilize;
        logic [rcpwd_pkg::OUT_CH-1:0]                           lost_mask;
        logic [rcpwd_pkg::OUT_CH-1:0][rcpwd_pkg::PULSE_W-1:0]   pulse;
    } decoded_tick_t;

    // ------------------------------------------------------------------------
    // Signals to and from the core. Everything the core samples starts known.
    // ------------------------------------------------------------------------
    logic                             aclk     = 1'b0;
    logic                             aresetn  = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [rcpwd_pkg::S_DATA_W-1:0]   s_tdata  = '0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [rcpwd_pkg::M_DATA_W-1:0]   m_tdata;
    logic                             psel     = 1'b0;
    logic                             penable  = 1'b0;
    logic                             pwrite   = 1'b0;
    logic [rcpwd_pkg::ADDR_W-1:0]     paddr    = '0;
    logic [rcpwd_pkg::APB_W-1:0]      pwdata   = '0;
    logic [rcpwd_pkg::APB_W-1:0]      prdata;
    logic                             pready;

    rc_pulse_width_decoder_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        // s_tdata: [3:0] line_levels, [7:4] zero
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        // m_tdata: [11:0] pulse_ch1, [23:12] pulse_ch2, [35:24] pulse_ch3,
        //          [47:36] pulse_ch4, [51:48] lost_mask, [52] stabilize, [55:53] zero
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #(HALF_PERIOD) aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Scoreboard state.
    // ------------------------------------------------------------------------
    decoded_tick_t tick_results_q[$];
    int            mismatches      = 0;
    int            results_checked = 0;
    int            settings_used   = 0;
    int            stall_left      = 0;
    // When set, neither stream inserts idle cycles, so the core runs at full
    // rate; random traffic turns this on for stretches.
    logic          steady          = 1'b0;

    // ------------------------------------------------------------------------
    // Capture model: register copy plus per-channel edge and counter state.
    // ------------------------------------------------------------------------
    rcpwd_pkg::cfg_t                  decoder_cfg;
    logic [rcpwd_pkg::LEVEL_W-1:0]    prev_levels;
    logic [rcpwd_pkg::CHANNELS-1:0]   armed;
    logic [rcpwd_pkg::CHANNELS-1:0]   has_capture;
    logic [rcpwd_pkg::COUNT_BITS-1:0] high_count  [rcpwd_pkg::CHANNELS];
    logic [rcpwd_pkg::COUNT_BITS-1:0] width_latch [rcpwd_pkg::CHANNELS];
    logic [rcpwd_pkg::COUNT_BITS-1:0] age_count   [rcpwd_pkg::CHANNELS];

    function automatic logic [rcpwd_pkg::COUNT_BITS-1:0] sat_incr(
        input logic [rcpwd_pkg::COUNT_BITS-1:0] v);
        return (v == rcpwd_pkg::COUNT_MAX) ? v : v + 1'b1;
    endfunction

    // Advances the capture model by one tick and returns the result it causes.
    function automatic decoded_tick_t decode_tick(
        input logic [rcpwd_pkg::LEVEL_W-1:0] levels);
        decoded_tick_t                    r;
        logic                             captured;
        logic                             fell_back;
        logic [rcpwd_pkg::COUNT_BITS-1:0] w;
        r = '0;
        for (int ch = 0; ch < rcpwd_pkg::CHANNELS; ch++) begin
            captured = 1'b0;
            if (levels[ch] && !prev_levels[ch]) begin
                // A rising edge arms the channel and restarts its high time.
                armed[ch]      = 1'b1;
                high_count[ch] = '0;
            end else if (armed[ch]) begin
                high_count[ch] = sat_incr(high_count[ch]);
                if (!levels[ch] && prev_levels[ch]) begin
                    width_latch[ch] = high_count[ch];
                    has_capture[ch] = 1'b1;
                    armed[ch]       = 1'b0;
                    captured        = 1'b1;
                end
            end
            // A falling edge on an unarmed channel falls through untouched.
            age_count[ch] = captured ? '0 : sat_incr(age_count[ch]);
        end
        prev_levels = levels;

        for (int ch = 0; ch < rcpwd_pkg::OUT_CH; ch++) begin
            fell_back = 1'b1;
            w         = '0;
            if (ch < rcpwd_pkg::CHANNELS) begin
                w         = width_latch[ch];
                fell_back = !has_capture[ch]
                            || (age_count[ch] > decoder_cfg.loss_timeout)
                            || (w == '0);
            end
            if (fell_back) begin
                r.pulse[ch]     = decoder_cfg.fallback_pulse;
                r.lost_mask[ch] = 1'b1;
            end else if (w < decoder_cfg.pulse_min) begin
                // The lower bound wins when the window is inverted.
                r.pulse[ch] = decoder_cfg.pulse_min;
            end else if (w > decoder_cfg.pulse_max) begin
                r.pulse[ch] = decoder_cfg.pulse_max;
            end else begin
                r.pulse[ch] = w[rcpwd_pkg::PULSE_W-1:0];
            end
        end
        r.stabilize = (r.pulse[rcpwd_pkg::OUT_CH-1] >= decoder_cfg.mode_threshold);
        return r;
    endfunction

    task automatic reset_model();
        decoder_cfg.pulse_min      = rcpwd_pkg::PULSE_MIN_RST;
        decoder_cfg.pulse_max      = rcpwd_pkg::PULSE_MAX_RST;
        decoder_cfg.fallback_pulse = rcpwd_pkg::FALLBACK_PULSE_RST;
        decoder_cfg.loss_timeout   = rcpwd_pkg::LOSS_TIMEOUT_RST;
        decoder_cfg.mode_threshold = rcpwd_pkg::MODE_THRESHOLD_RST;
        prev_levels = '0;
        armed       = '0;
        has_capture = '0;
        for (int ch = 0; ch < rcpwd_pkg::CHANNELS; ch++) begin
            high_count[ch]  = '0;
            width_latch[ch] = '0;
            age_count[ch]   = '0;
        end
    endtask

    // ------------------------------------------------------------------------
    // Input side. Every task here is entered and left on a rising edge, and
    // all core inputs are driven with nonblocking assignments there, so the
    // core and the checker both see the values from before the edge.
    // ------------------------------------------------------------------------

    // Sends one tick, after a random idle gap unless running steady. The
    // prediction is made at the edge where the transfer happens, so the model
    // sees ticks in exactly the order the core takes them.
    task automatic send_tick(input logic [rcpwd_pkg::LEVEL_W-1:0] levels);
        int gap;
        gap = steady ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(rcpwd_pkg::S_DATA_W-rcpwd_pkg::LEVEL_W){1'b0}}, levels};
        do @(posedge aclk); while (!s_tready);
        tick_results_q.push_back(decode_tick(levels));
    endtask

    // Stops the input stream and waits until every predicted result has been
    // taken. Every tick gives a registered result, so the SETTLE_CYCLES margin
    // afterwards leaves the core fully idle.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (tick_results_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // One APB write: a setup phase, an access phase held until pready, then
    // an idle bus phase so back-to-back writes never retarget psel at once.
    task automatic write_reg(input rcpwd_pkg::reg_idx_t idx,
                             input logic [rcpwd_pkg::APB_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            rcpwd_pkg::REG_PULSE_MIN:
                decoder_cfg.pulse_min      = value[rcpwd_pkg::PULSE_W-1:0];
            rcpwd_pkg::REG_PULSE_MAX:
                decoder_cfg.pulse_max      = value[rcpwd_pkg::PULSE_W-1:0];
            rcpwd_pkg::REG_FALLBACK_PULSE:
                decoder_cfg.fallback_pulse = value[rcpwd_pkg::PULSE_W-1:0];
            rcpwd_pkg::REG_LOSS_TIMEOUT:
                decoder_cfg.loss_timeout   = value[rcpwd_pkg::TIMEOUT_W-1:0];
            rcpwd_pkg::REG_MODE_THRESHOLD:
                decoder_cfg.mode_threshold = value[rcpwd_pkg::PULSE_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // Drains the stream, then writes all five registers.
    task automatic configure(input rcpwd_pkg::cfg_t c);
        wait_for_results();
        write_reg(rcpwd_pkg::REG_PULSE_MIN,      rcpwd_pkg::APB_W'(c.pulse_min));
        write_reg(rcpwd_pkg::REG_PULSE_MAX,      rcpwd_pkg::APB_W'(c.pulse_max));
        write_reg(rcpwd_pkg::REG_FALLBACK_PULSE, rcpwd_pkg::APB_W'(c.fallback_pulse));
        write_reg(rcpwd_pkg::REG_LOSS_TIMEOUT,   rcpwd_pkg::APB_W'(c.loss_timeout));
        write_reg(rcpwd_pkg::REG_MODE_THRESHOLD, rcpwd_pkg::APB_W'(c.mode_threshold));
        settings_used++;
    endtask

    // ------------------------------------------------------------------------
    // Result side: checks each transfer against the oldest prediction and
    // draws a random stall after it.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : result_checker
        decoded_tick_t got;
        decoded_tick_t want;
        int            stall;
        if (aresetn && m_tvalid && m_tready) begin
            got = decoded_tick_t'(m_tdata);
            if (tick_results_q.size() == 0) begin
                $display("%0t ns: result transfer with none expected, got %h",
                         $time, m_tdata);
                mismatches++;
            end else begin
                want = tick_results_q.pop_front();
                results_checked++;
                for (int ch = 0; ch < rcpwd_pkg::OUT_CH; ch++) begin
                    if (got.pulse[ch] !== want.pulse[ch]) begin
                        $display("%0t ns: pulse_ch%0d expected %0d, got %0d",
                                 $time, ch + 1, want.pulse[ch], got.pulse[ch]);
                        mismatches++;
                    end
                end
                if (got.lost_mask !== want.lost_mask) begin
                    $display("%0t ns: lost_mask expected %b, got %b",
                             $time, want.lost_mask, got.lost_mask);
                    mismatches++;
                end
                if (got.stabilize !== want.stabilize) begin
                    $display("%0t ns: stabilize expected %b, got %b",
                             $time, want.stabilize, got.stabilize);
                    mismatches++;
                end
                if (got.pad !== want.pad) begin
                    $display("%0t ns: m_tdata padding expected %b, got %b",
                             $time, want.pad, got.pad);
                    mismatches++;
                end
            end
        end

        // Ready handling: after a transfer, hold ready low for a random
        // number of cycles, counted down one per edge.
        if (!m_tready) begin
            if (stall_left == 0) begin
                m_tready <= 1'b1;
            end else begin
                stall_left--;
            end
        end else if (m_tvalid) begin
            stall = steady ? 0 : $urandom_range(0, MAX_IDLE);
            if (stall > 0) begin
                m_tready   <= 1'b0;
                stall_left = stall - 1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Directed tests.
    // ------------------------------------------------------------------------

    // Default registers. Lines high on the very first tick count as rising
    // edges; before that capture completes every channel falls back, and the
    // fallback 1500 meets the default threshold exactly. A width of 2 is then
    // lifted to the default minimum of 1000.
    task automatic test_reset_defaults();
        send_tick(4'b1111);
        send_tick(4'b1111);
        send_tick(4'b0000);
    endtask

    // Widest window, fallback at its top and a zero timeout: a channel is
    // valid only on its capture tick. Width 1 is the shortest capture.
    // The last two channels captured long ago and must report the fallback.
    task automatic test_open_window_zero_timeout();
        rcpwd_pkg::cfg_t c;
        c.pulse_min      = '0;
        c.pulse_max      = '1;
        c.fallback_pulse = '1;
        c.loss_timeout   = '0;
        c.mode_threshold = '0;
        configure(c);
        send_tick(4'b0011);
        send_tick(4'b0001);
        send_tick(4'b0000);
        send_tick(4'b0000);
    endtask

    // Minimum above maximum: short widths give the minimum, long ones the
    // maximum. A timeout of 2 keeps a capture valid for ages 0 to 2 only.
    // The threshold equals the minimum, so the stabilize flag tests equality.
    task automatic test_inverted_window();
        rcpwd_pkg::cfg_t c;
        c.pulse_min      = 12'd5;
        c.pulse_max      = 12'd3;
        c.fallback_pulse = '0;
        c.loss_timeout   = 16'd2;
        c.mode_threshold = 12'd5;
        configure(c);
        send_tick(4'b1100);
        send_tick(4'b1100);
        repeat (4) send_tick(4'b0100);
        repeat (3) send_tick(4'b0000);
    endtask

    // ------------------------------------------------------------------------
    // Random traffic: per-channel pulse trains with random run lengths, so
    // edges keep arming and capturing, mixed with ticks of random levels.
    // Each phase draws new registers, extremes included, and the windows are
    // sized so the short random widths land below, inside and above them.
    // ------------------------------------------------------------------------
    task automatic test_random_traffic();
        rcpwd_pkg::cfg_t               c;
        logic [rcpwd_pkg::LEVEL_W-1:0] levels;
        int                            run_left [rcpwd_pkg::CHANNELS];
        int                            max_run;
        levels = '0;
        for (int ch = 0; ch < rcpwd_pkg::CHANNELS; ch++) run_left[ch] = 0;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case ($urandom_range(0, 5))
                0:       c.pulse_min = '0;
                1:       c.pulse_min = '1;
                default: c.pulse_min = rcpwd_pkg::PULSE_W'($urandom_range(0, 40));
            endcase
            case ($urandom_range(0, 5))
                0:       c.pulse_max = '0;
                1:       c.pulse_max = '1;
                default: c.pulse_max = rcpwd_pkg::PULSE_W'($urandom_range(0, 48));
            endcase
            case ($urandom_range(0, 3))
                0:       c.fallback_pulse = '0;
                1:       c.fallback_pulse = '1;
                default: c.fallback_pulse = rcpwd_pkg::PULSE_W'($urandom_range(0, 4095));
            endcase
            case ($urandom_range(0, 7))
                0:       c.loss_timeout = '0;
                1:       c.loss_timeout = 16'd1;
                2:       c.loss_timeout = rcpwd_pkg::COUNT_MAX - 1'b1;
                3:       c.loss_timeout = '1;
                default: c.loss_timeout = rcpwd_pkg::TIMEOUT_W'($urandom_range(1, 80));
            endcase
            case ($urandom_range(0, 4))
                0:       c.mode_threshold = '0;
                1:       c.mode_threshold = '1;
                2:       c.mode_threshold = c.fallback_pulse;
                default: c.mode_threshold = rcpwd_pkg::PULSE_W'($urandom_range(0, 48));
            endcase
            configure(c);
            max_run = $urandom_range(2, 40);
            for (int n = 0; n < RANDOM_TICKS / RANDOM_PHASES; n++) begin
                if (n % 64 == 0) steady = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 99) < 12) begin
                    levels = rcpwd_pkg::LEVEL_W'($urandom_range(0, 15));
                end else begin
                    for (int ch = 0; ch < rcpwd_pkg::CHANNELS; ch++) begin
                        if (run_left[ch] == 0) begin
                            levels[ch]   = ~levels[ch];
                            run_left[ch] = $urandom_range(1, max_run);
                        end else begin
                            run_left[ch]--;
                        end
                    end
                end
                send_tick(levels);
            end
        end
        steady = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence: one reset, the directed tests, then random phases. Each
    // configure call first holds the sender back until every expected result
    // has arrived, so registers only change while the core is idle.
    // ------------------------------------------------------------------------
    initial begin
        reset_model();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_open_window_zero_timeout();
        test_inverted_window();
        test_random_traffic();

        wait_for_results();
        $display("Checked %0d result transfers over %0d register settings plus defaults,",
                 results_checked, settings_used);
        $display("covering clamp extremes, inverted windows, short timeouts and stalls.");
        if (mismatches == 0) begin
            $display("rc_pulse_width_decoder_core: match");
        end else begin
            $display("rc_pulse_width_decoder_core: mismatch");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run, with the longest idle gap
    // and the longest stall on every tick.
    initial begin
        #(10_000_000);
        $display("Timeout with %0d results still expected.", tick_results_q.size());
        $display("rc_pulse_width_decoder_core: mismatch");
        $finish;
    end

endmodule

`default_nettype wire
